/* sv/mpfd_pkg.sv */
`default_nettype none

package mpfd_pkg;

  localparam int COLUMNS = 128;
  localparam int ROWS    = 64;

  localparam int COL_W       = 7;
  localparam int ROW_W       = 6;
  localparam int PAGE_W      = 3;
  localparam int STORE_DEPTH = 1024;
  localparam int ADDR_W      = 10;

  localparam logic [1:0] FUNC_POINT = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_VLINE = 2'd2;

  localparam logic [1:0] KIND_CMD    = 2'd0;
  localparam logic [1:0] KIND_DATA   = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // controller command bases
  localparam logic [7:0] CMD_PAGE   = 8'hB0;
  localparam logic [7:0] CMD_COL_HI = 8'h10;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] x_coord;
    logic [7:0] y_coord;
    logic [7:0] y_end;
    logic       color;
  } req_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] byte_value;
    logic       ok;
    logic       pixel;
    logic       last;
  } res_t;

endpackage

`default_nettype wire

/* sv/mono_page_framebuffer_draw_unit.sv */
`default_nettype none

// Channel   Ports                Transfer
// request   start, busy, req     rising edge with start high and busy low
// result    res_strobe, res      rising edge ending the cycle res_strobe is high
//
// Out-of-range and unused requests: one status result the cycle after the transfer.
// Read point: one frame store read, then one status result. Draw point: four bytes.
// Vertical line: the four controller bytes per page touched, at one a cycle; the
// next page's read overlaps the current bytes.
// After reset the frame store is cleared one entry a cycle; busy stays high until all 1024 are done.
// The receiver cannot stall; results go out one per cycle.
module mono_page_framebuffer_draw_unit
  import mpfd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic      busy,
  input  wire req_t req,
  output logic      res_strobe,
  output res_t      res
);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_READ  = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

  state_t              state;
  logic [ADDR_W-1:0]   clr_addr;
  logic [1:0]          func;
  logic                color;
  logic [COL_W-1:0]    col;
  logic [PAGE_W-1:0]   page;
  logic [PAGE_W-1:0]   end_page;
  logic [2:0]          lo;
  logic [2:0]          hi;
  logic [1:0]          cnt;
  logic [7:0]          data;

  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr;
  logic [7:0]          mem_wdata;
  logic [ADDR_W-1:0]   mem_raddr;
  logic [7:0]          mem_rdata;

  function automatic logic [ADDR_W-1:0] store_addr(input logic [PAGE_W-1:0] p,
                                                   input logic [COL_W-1:0] c);
    store_addr = ADDR_W'(ADDR_W'(p) * ADDR_W'(COLUMNS) + ADDR_W'(c));
  endfunction

  // request decode
  logic              accept;
  logic              pt_ok;
  logic              ln_ok;
  logic              req_ok;
  logic [ROW_W-1:0]  y0c;
  logic [ROW_W-1:0]  y1c;
  logic [ROW_W-1:0]  ylo;
  logic [ROW_W-1:0]  yhi;
  logic [COL_W-1:0]  a_col;
  logic [ROW_W-1:0]  a_top;
  logic [ROW_W-1:0]  a_bot;

  assign accept = start && !busy;
  assign pt_ok  = ({1'b0, req.x_coord} < 9'(COLUMNS)) && ({1'b0, req.y_coord} < 9'(ROWS));
  assign ln_ok  = ({2'b00, req.x_coord[6:0]} < 9'(COLUMNS));

  always_comb begin
    y0c = (req.y_coord > 8'(ROWS - 1)) ? ROW_W'(ROWS - 1) : req.y_coord[ROW_W-1:0];
    y1c = (req.y_end > 8'(ROWS - 1)) ? ROW_W'(ROWS - 1) : req.y_end[ROW_W-1:0];
    ylo = (y0c > y1c) ? y1c : y0c;
    yhi = (y0c > y1c) ? y0c : y1c;
    a_col = COL_W'(req.x_coord);
    case (req.func)
      FUNC_POINT, FUNC_READ: begin
        req_ok = pt_ok;
        a_top  = req.y_coord[ROW_W-1:0];
        a_bot  = req.y_coord[ROW_W-1:0];
      end
      FUNC_VLINE: begin
        req_ok = ln_ok;
        a_top  = ylo;
        a_bot  = yhi;
      end
      default: begin
        req_ok = 1'b0;
        a_top  = ylo;
        a_bot  = yhi;
      end
    endcase
  end

  // span mask of the current page and merged byte
  logic [7:0] mask;
  logic [7:0] merged;
  logic       final_page;

  // pages above the last one are filled down to their bottom row
  assign mask       = (8'hFF << lo) & (final_page ? (8'hFF >> (3'd7 - hi)) : 8'hFF);
  assign merged     = color ? (mem_rdata | mask) : (mem_rdata & ~mask);
  assign final_page = (page == end_page);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = store_addr(page, col);
    mem_wdata = merged;
    mem_raddr = store_addr(page + PAGE_W'(1), col);
    case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = 8'h00;
      end
      ST_IDLE: begin
        mem_raddr = store_addr(a_top[ROW_W-1:3], a_col);
      end
      ST_READ: begin
        mem_we = (func != FUNC_READ);
      end
      default: ;
    endcase
  end

  mpfd_ram #(
    .WIDTH(8),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  assign busy = rst || (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_addr   <= '0;
      cnt        <= '0;
      res_strobe <= 1'b0;
    end else begin
      res_strobe <= 1'b0;
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == ADDR_W'(STORE_DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            if (req_ok) begin
              state <= ST_READ;
            end else begin
              res_strobe <= 1'b1;
            end
          end
        end
        ST_READ: begin
          res_strobe <= 1'b1;
          if (func == FUNC_READ) begin
            state <= ST_IDLE;
          end else begin
            state <= ST_EMIT;
            cnt   <= 2'd1;
          end
        end
        ST_EMIT: begin
          res_strobe <= 1'b1;
          cnt        <= cnt + 2'd1;
          if (cnt == 2'd3) begin
            state <= final_page ? ST_IDLE : ST_READ;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          func     <= req.func;
          color    <= req.color;
          col      <= a_col;
          page     <= a_top[ROW_W-1:3];
          end_page <= a_bot[ROW_W-1:3];
          lo       <= a_top[2:0];
          hi       <= a_bot[2:0];
          res      <= '{kind: KIND_STATUS, byte_value: 8'h00, ok: 1'b0, pixel: 1'b0,
                        last: 1'b1};
        end
      end
      ST_READ: begin
        data <= merged;
        if (func == FUNC_READ) begin
          res <= '{kind: KIND_STATUS, byte_value: 8'h00, ok: 1'b1,
                   pixel: |(mem_rdata & mask), last: 1'b1};
        end else begin
          res <= '{kind: KIND_CMD, byte_value: CMD_PAGE | 8'(page), ok: 1'b1,
                   pixel: 1'b0, last: 1'b0};
        end
      end
      ST_EMIT: begin
        case (cnt)
          2'd1: res <= '{kind: KIND_CMD, byte_value: CMD_COL_HI | 8'(col[6:4]), ok: 1'b1,
                         pixel: 1'b0, last: 1'b0};
          2'd2: res <= '{kind: KIND_CMD, byte_value: 8'(col[3:0]), ok: 1'b1,
                         pixel: 1'b0, last: 1'b0};
          default: begin
            res <= '{kind: KIND_DATA, byte_value: data, ok: 1'b1, pixel: 1'b0,
                     last: final_page};
            // next page of a line starts at its top row
            page <= page + PAGE_W'(1);
            lo   <= 3'd0;
          end
        endcase
      end
      default: ;
    endcase
  end

`ifndef SYNTH
  a_read_emits: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |=> res_strobe)
    else $error("store read not followed by a result");

  a_status_last: assert property (@(posedge clk) disable iff (rst)
    (res_strobe && res.kind == KIND_STATUS) |-> res.last)
    else $error("status result without last");

  a_write_state: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == ST_READ || state == ST_CLEAR))
    else $error("frame store write outside read-modify-write or clear");

  a_data_after_cmd: assert property (@(posedge clk) disable iff (rst)
    (res_strobe && res.kind == KIND_DATA) |-> $past(res_strobe) && $past(res.kind) == KIND_CMD)
    else $error("data byte without preceding column command");
`endif

endmodule

`default_nettype wire

/* sv/mpfd_ram.sv */
`default_nettype none

module mpfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* dv/tb_top.sv */
`default_nettype none

module tb_top;
  import mpfd_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 450;
  localparam int MAX_PAGE_BYTES = 32;

  // single status replies that can be read straight off the spec
  localparam res_t OFF_SCREEN  = '{KIND_STATUS, 8'h00, 1'b0, 1'b0, 1'b1};
  localparam res_t BLANK_PIXEL = '{KIND_STATUS, 8'h00, 1'b1, 1'b0, 1'b1};
  localparam res_t MODELED     = '0;

  typedef struct {
    req_t cmd;
    bit   fixed;
    res_t reply;
  } probe_t;

  typedef struct {
    bit   fixed;
    res_t reply;
  } typed_reply_t;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  req_t req;
  logic res_strobe;
  res_t res;

  logic [7:0]   page_image [STORE_DEPTH] = '{default: 8'h00};
  res_t         rendered[$];
  res_t         bytes_due[$];
  typed_reply_t typed_q[$];
  int           fail_count = 0;
  int           burst_left = 0;

  probe_t probes [23] = '{
    '{'{FUNC_READ,   8'd0,   8'd0,   8'd0,   1'b0}, 1'b1, BLANK_PIXEL},
    '{'{FUNC_READ,   8'd127, 8'd63,  8'd0,   1'b1}, 1'b1, BLANK_PIXEL},
    '{'{FUNC_POINT,  8'd128, 8'd0,   8'd0,   1'b1}, 1'b1, OFF_SCREEN},
    '{'{FUNC_POINT,  8'd0,   8'd64,  8'd0,   1'b1}, 1'b1, OFF_SCREEN},
    '{'{FUNC_READ,   8'd255, 8'd255, 8'd255, 1'b1}, 1'b1, OFF_SCREEN},
    '{'{FUNC_UNUSED, 8'd3,   8'd3,   8'd3,   1'b1}, 1'b1, OFF_SCREEN},
    '{'{FUNC_POINT,  8'd0,   8'd0,   8'd0,   1'b1}, 1'b0, MODELED},
    '{'{FUNC_POINT,  8'd127, 8'd63,  8'd0,   1'b1}, 1'b0, MODELED},
    '{'{FUNC_READ,   8'd0,   8'd0,   8'd0,   1'b0}, 1'b0, MODELED},
    '{'{FUNC_READ,   8'd127, 8'd63,  8'd0,   1'b0}, 1'b0, MODELED},
    '{'{FUNC_POINT,  8'd127, 8'd63,  8'd0,   1'b0}, 1'b0, MODELED},
    '{'{FUNC_READ,   8'd127, 8'd63,  8'd0,   1'b0}, 1'b0, MODELED},
    // full-height line, then cleared with the ends swapped
    '{'{FUNC_VLINE,  8'd5,   8'd0,   8'd63,  1'b1}, 1'b0, MODELED},
    '{'{FUNC_VLINE,  8'd5,   8'd63,  8'd0,   1'b0}, 1'b0, MODELED},
    // both ends clamped, column masked
    '{'{FUNC_VLINE,  8'd200, 8'd255, 8'd255, 1'b1}, 1'b0, MODELED},
    '{'{FUNC_VLINE,  8'd9,   8'd3,   8'd3,   1'b1}, 1'b0, MODELED},
    '{'{FUNC_VLINE,  8'd9,   8'd10,  8'd12,  1'b1}, 1'b0, MODELED},
    '{'{FUNC_VLINE,  8'd9,   8'd7,   8'd8,   1'b1}, 1'b0, MODELED},
    '{'{FUNC_VLINE,  8'd255, 8'd0,   8'd200, 1'b1}, 1'b0, MODELED},
    '{'{FUNC_READ,   8'd127, 8'd40,  8'd0,   1'b0}, 1'b0, MODELED},
    '{'{FUNC_POINT,  8'd64,  8'd32,  8'd0,   1'b1}, 1'b0, MODELED},
    '{'{FUNC_READ,   8'd64,  8'd32,  8'd0,   1'b0}, 1'b0, MODELED},
    '{'{FUNC_VLINE,  8'd128, 8'd100, 8'd0,   1'b0}, 1'b0, MODELED}
  };

  mono_page_framebuffer_draw_unit i_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .req        (req),
    .res_strobe (res_strobe),
    .res        (res)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic int unsigned slot(int unsigned pg, int unsigned col);
    return (pg * COLUMNS + col) % STORE_DEPTH;
  endfunction

  function automatic logic [7:0] paint(logic [7:0] old, logic [7:0] mask, logic color);
    return color ? (old | mask) : (old & ~mask);
  endfunction

  function automatic res_t status_reply(logic ok, logic pix);
    return '{KIND_STATUS, 8'h00, ok, pix, 1'b1};
  endfunction

  // rewrite one page byte and queue the four controller bytes that carry it
  function automatic void emit_page(int unsigned pg, int unsigned col, logic [7:0] value,
                                    logic fin);
    page_image[slot(pg, col)] = value;
    rendered.push_back('{KIND_CMD, CMD_PAGE + 8'(pg & 7), 1'b1, 1'b0, 1'b0});
    rendered.push_back('{KIND_CMD, CMD_COL_HI + 8'((col >> 4) & 7), 1'b1, 1'b0, 1'b0});
    rendered.push_back('{KIND_CMD, 8'(col & 'h0F), 1'b1, 1'b0, 1'b0});
    rendered.push_back('{KIND_DATA, value, 1'b1, 1'b0, fin});
  endfunction

  function automatic void render_request(req_t r);
    int unsigned x, y, col, y0, y1, pg, t;
    logic [7:0] old, mask, bitm;
    rendered.delete();
    case (r.func)
      FUNC_POINT, FUNC_READ: begin
        x = 32'(r.x_coord);
        y = 32'(r.y_coord);
        if (x >= COLUMNS || y >= ROWS) begin
          rendered.push_back(status_reply(1'b0, 1'b0));
        end else begin
          pg   = y >> 3;
          bitm = 8'(1 << (y & 7));
          old  = page_image[slot(pg, x)];
          if (r.func == FUNC_READ)
            rendered.push_back(status_reply(1'b1, |(old & bitm)));
          else
            emit_page(pg, x, paint(old, bitm, r.color), 1'b1);
        end
      end
      FUNC_VLINE: begin
        col = r.x_coord & 'h7F;
        if (col >= COLUMNS) begin
          rendered.push_back(status_reply(1'b0, 1'b0));
        end else begin
          y0 = (r.y_coord > ROWS - 1) ? ROWS - 1 : r.y_coord;
          y1 = (r.y_end > ROWS - 1) ? ROWS - 1 : r.y_end;
          if (y0 > y1) begin
            t  = y0;
            y0 = y1;
            y1 = t;
          end
          // top page first; only the last page byte carries the end mark
          while (rendered.size() + 4 <= MAX_PAGE_BYTES) begin
            pg   = y0 >> 3;
            old  = page_image[slot(pg, col)];
            mask = 8'(8'hFF << (y0 & 7));
            if (pg != (y1 >> 3)) begin
              emit_page(pg, col, paint(old, mask, r.color), 1'b0);
              y0 = (pg + 1) << 3;
            end else begin
              mask &= 8'(8'hFF >> (7 - (y1 & 7)));
              emit_page(pg, col, paint(old, mask, r.color), 1'b1);
              break;
            end
          end
        end
      end
      default: begin
        rendered.push_back(status_reply(1'b0, 1'b0));
      end
    endcase
  endfunction

  function automatic req_t random_request();
    req_t r;
    int unsigned pick;
    pick      = $urandom_range(0, 99);
    r.color   = 1'($urandom_range(0, 1));
    r.y_end   = 8'($urandom_range(0, 63));
    if (pick < 8) begin
      // noise: any selector, any coordinates
      r.func    = 2'($urandom_range(0, 3));
      r.x_coord = 8'($urandom);
      r.y_coord = 8'($urandom);
      r.y_end   = 8'($urandom);
    end else begin
      r.func = (pick < 40) ? FUNC_POINT : (pick < 65) ? FUNC_READ : FUNC_VLINE;
      // half of the non-noise traffic lands in a small corner so reads see earlier draws
      if ($urandom_range(0, 1)) begin
        r.x_coord = 8'($urandom_range(0, 7));
        r.y_coord = 8'($urandom_range(0, 15));
        r.y_end   = 8'($urandom_range(0, 15));
      end else begin
        r.x_coord = 8'($urandom_range(0, 127));
        r.y_coord = 8'($urandom_range(0, 63));
      end
      if (r.func == FUNC_VLINE && $urandom_range(0, 5) == 0) begin
        r.x_coord = 8'($urandom);
        r.y_coord = 8'($urandom);
        r.y_end   = 8'($urandom);
      end
    end
    return r;
  endfunction

  task automatic issue(req_t r, bit fixed, res_t reply);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      if (gap > 0) begin
        start <= 1'b0;
        req   <= random_request();
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    typed_q.push_back('{fixed, reply});
    start <= 1'b1;
    req   <= r;
    do @(posedge clk); while (busy);
  endtask

  // result check first, then expectations for a transfer at the same edge
  always @(posedge clk) begin : scoreboard
    res_t want;
    typed_reply_t typed;
    if (!rst) begin
      if (res_strobe) begin
        if (bytes_due.size() == 0) begin
          $error("unexpected result: %p", res);
          fail_count++;
        end else begin
          want = bytes_due.pop_front();
          if (res.kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, res.kind);
            fail_count++;
          end
          if (res.byte_value !== want.byte_value) begin
            $error("byte_value: expected %02h, got %02h", want.byte_value, res.byte_value);
            fail_count++;
          end
          if (res.ok !== want.ok) begin
            $error("ok: expected %0b, got %0b", want.ok, res.ok);
            fail_count++;
          end
          if (res.pixel !== want.pixel) begin
            $error("pixel: expected %0b, got %0b", want.pixel, res.pixel);
            fail_count++;
          end
          if (res.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, res.last);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        typed = typed_q.pop_front();
        render_request(req);
        if (typed.fixed)
          bytes_due.push_back(typed.reply);
        else
          foreach (rendered[i]) bytes_due.push_back(rendered[i]);
      end
    end
  end

  initial begin
    rst   <= 1'b1;
    start <= 1'b0;
    req   <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    foreach (probes[i]) issue(probes[i].cmd, probes[i].fixed, probes[i].reply);
    repeat (RANDOM_ITEMS) issue(random_request(), 1'b0, MODELED);
    start <= 1'b0;
    while (bytes_due.size() != 0) @(posedge clk);
    // longest line is eight pages: let any stray transfer show up
    repeat (40) @(posedge clk);
    if (fail_count == 0 && bytes_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
